// File: hw/rtl/ezr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_pkg: shared types, constants and functions of the ZXZ rotation block
// Fixed formats, arctangent table construction and output rounding.
// ----------------------------------------------------------------------------
package ezr_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int OUT_FRAC_BITS   = 16;
   localparam int CORDIC_STEPS_DEF = 18;
   localparam int TAB_LEN  = 32;
   localparam int IN_W     = 26;
   localparam int OUT_W    = 18;
   localparam int RED_W    = 40;
   localparam int Z_W      = 43;
   localparam int XY_W     = 43;
   localparam int TRIG_W   = 32;
   localparam int PROD_W   = 64;
   localparam int SUM_W    = 66;
   localparam int EMIT_SH  = 60 - OUT_FRAC_BITS;

   // Angle reduction: offset by whole turns so that the value is never negative,
   // then a short restoring compare-and-subtract chain.
   localparam longint FULL_L = longint'(360) << ANGLE_FRAC_BITS;
   localparam longint NWRAP  = ((longint'(1) << (IN_W - 1)) + FULL_L - 1) / FULL_L;
   localparam int RED_STEPS  = $clog2(2 * NWRAP);
   localparam logic [RED_W-1:0] FULL = RED_W'(FULL_L);
   localparam logic [RED_W-1:0] OFS  = RED_W'(FULL_L * NWRAP);

   localparam logic signed [Z_W-1:0] HALF  = Z_W'(longint'(180) << 32);
   localparam logic signed [Z_W-1:0] QUART = Z_W'(longint'(90) << 32);
   localparam logic signed [XY_W-1:0] GAIN = XY_W'(64'sd667681663043);

   localparam logic signed [SUM_W-1:0] EMIT_RND = SUM_W'(longint'(1) << (EMIT_SH - 1));
   localparam logic signed [SUM_W-1:0] EMIT_ONE = SUM_W'(longint'(1) << OUT_FRAC_BITS);
   localparam logic signed [SUM_W-1:0] EMIT_HI  = SUM_W'((longint'(1) << (OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] EMIT_LO  = -SUM_W'(longint'(1) << (OUT_W - 1));

   typedef struct packed {
      logic signed [Z_W-1:0] z;
      logic                  flip;
   } angle_type;

   typedef struct packed {
      angle_type a;
      angle_type b;
      angle_type c;
   } cls_type;

   // Unsigned 64-bit long division, used only while building constants.
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         q   = {q[62:0], 1'b0};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q.60 radians, truncated Taylor sum.
   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      int          odd;
      int          prod;
      logic        done;
      sum  = '0;
      done = 1'b0;
      for (int k = 0; k < 64; k++) begin
         odd  = 2 * k + 1;
         prod = i * odd;
         if (prod > 60) done = 1'b1;
         if (!done) begin
            term = udiv(64'd1 << (60 - prod), 64'(odd));
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // atan(1/3) in Q.60 radians.
   function automatic logic [63:0] atan_third();
      logic [63:0] one;
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] term;
      logic        done;
      one  = 64'd1 << 60;
      p    = 64'd3;
      sum  = '0;
      done = 1'b0;
      for (int k = 0; k < 64; k++) begin
         if (!done) begin
            term = udiv(udiv(one, p), 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
            if (p > udiv(one, 64'd9)) done = 1'b1;
            else                      p = p * 64'd9;
         end
      end
      return sum;
   endfunction

   // CORDIC step angle atan(2^-i) in Q.32 degrees.
   function automatic logic [39:0] atan_deg(input int i);
      logic [63:0] quarter;
      logic [63:0] num;
      logic [63:0] q;
      logic [63:0] r;
      if (i == 0) begin
         r = 64'd45 << 32;
      end else begin
         quarter = atan_pow2(1) + atan_third();
         num = atan_pow2(i);
         q   = '0;
         for (int b = 0; b < 38; b++) begin
            num = num << 1;
            q   = q << 1;
            if (num >= quarter) begin
               num  = num - quarter;
               q[0] = 1'b1;
            end
         end
         r = (q * 64'd45 + 64'd32) >> 6;
      end
      return r[39:0];
   endfunction

   // Round a Q.60 value to the output format and saturate it.
   function automatic logic signed [OUT_W-1:0] emit(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = (v + EMIT_RND) >>> EMIT_SH;
      if (t > EMIT_ONE)  t = EMIT_ONE;
      if (t < -EMIT_ONE) t = -EMIT_ONE;
      if (t > EMIT_HI)   t = EMIT_HI;
      if (t < EMIT_LO)   t = EMIT_LO;
      return t[OUT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/ezr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_req_if: request channel
// Carries the three Euler angles with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ezr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ezr_pkg::IN_W-1:0]     first_z_angle;
   logic signed [ezr_pkg::IN_W-1:0]     x_angle;
   logic signed [ezr_pkg::IN_W-1:0]     second_z_angle;

   modport source (output valid, first_z_angle, x_angle, second_z_angle, input ready);
   modport sink   (input valid, first_z_angle, x_angle, second_z_angle, output ready);
endinterface

// File: hw/rtl/ezr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_rsp_if: response channel
// Carries the nine rotation matrix elements with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ezr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ezr_pkg::OUT_W-1:0]   r00;
   logic signed [ezr_pkg::OUT_W-1:0]   r01;
   logic signed [ezr_pkg::OUT_W-1:0]   r02;
   logic signed [ezr_pkg::OUT_W-1:0]   r10;
   logic signed [ezr_pkg::OUT_W-1:0]   r11;
   logic signed [ezr_pkg::OUT_W-1:0]   r12;
   logic signed [ezr_pkg::OUT_W-1:0]   r20;
   logic signed [ezr_pkg::OUT_W-1:0]   r21;
   logic signed [ezr_pkg::OUT_W-1:0]   r22;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   output ready);
endinterface

// File: hw/rtl/euler_angles_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_core: ZXZ Euler angles to rotation matrix
// Turns three angles in degrees into R = Z(a) X(b) Z(c), nine Q1.16 elements.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req_ch    in          first_z_angle, x_angle, second_z_angle (Q9.16 deg)
//   rsp_ch    out         r00 .. r22 (Q1.16, saturated to +-1)
//
// One beat is accepted per cycle and one result leaves per cycle once the
// pipeline is full and the response channel is ready. Between request and
// response lie one intake register, one queue slot, one register per CORDIC
// micro-rotation plus its rounding register, and four stages of products and
// sums. Reset is synchronous and clears only valid state. A stalled response
// holds the whole arithmetic pipeline; the two-entry queue then absorbs beats
// so intake keeps going until it fills.
//
module euler_angles_to_rotation_matrix_core #(
   parameter int CORDIC_STEPS = ezr_pkg::CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ezr_req_if.sink   req_ch,
   ezr_rsp_if.source rsp_ch
);
   import ezr_pkg::*;

   // Classified beat between intake and queue.
   cls_type cls_data;
   logic    cls_valid;
   logic    cls_ready;

   // Queue output feeding the arithmetic pipeline.
   cls_type q_data;
   logic    q_valid;

   // The back pipeline moves as one unit whenever the output register can
   // take a new value.
   logic    back_en;
   logic    mat_valid;

   logic [2:0] trig_valid;
   logic signed [TRIG_W-1:0] sa;
   logic signed [TRIG_W-1:0] ca;
   logic signed [TRIG_W-1:0] sb;
   logic signed [TRIG_W-1:0] cb;
   logic signed [TRIG_W-1:0] sc;
   logic signed [TRIG_W-1:0] cc;

   assign back_en = !mat_valid || rsp_ch.ready;

   ezr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cls_data  (cls_data),
      .cls_valid (cls_valid),
      .cls_ready (cls_ready)
   );

   ezr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (cls_data),
      .push_valid (cls_valid),
      .push_ready (cls_ready),
      .pop_data   (q_data),
      .pop_valid  (q_valid),
      .pop_ready  (back_en)
   );

   // Three identical CORDIC pipelines run in lock step, one per angle.
   ezr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (q_valid),
      .ang       (q_data.a),
      .out_valid (trig_valid[0]),
      .sin_q30   (sa),
      .cos_q30   (ca)
   );

   ezr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (q_valid),
      .ang       (q_data.b),
      .out_valid (trig_valid[1]),
      .sin_q30   (sb),
      .cos_q30   (cb)
   );

   ezr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_c (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (q_valid),
      .ang       (q_data.c),
      .out_valid (trig_valid[2]),
      .sin_q30   (sc),
      .cos_q30   (cc)
   );

   ezr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (&trig_valid),
      .sa        (sa),
      .ca        (ca),
      .sb        (sb),
      .cb        (cb),
      .sc        (sc),
      .cc        (cc),
      .out_valid (mat_valid),
      .r00       (rsp_ch.r00),
      .r01       (rsp_ch.r01),
      .r02       (rsp_ch.r02),
      .r10       (rsp_ch.r10),
      .r11       (rsp_ch.r11),
      .r12       (rsp_ch.r12),
      .r20       (rsp_ch.r20),
      .r21       (rsp_ch.r21),
      .r22       (rsp_ch.r22)
   );

   assign rsp_ch.valid = mat_valid;
endmodule

// File: hw/rtl/ezr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_front: request intake
// Reduces each angle modulo one turn, folds it into +-90 degrees and
// registers the classified beat.
// ----------------------------------------------------------------------------
module ezr_front (
   input  logic              clock,
   input  logic              reset,
   ezr_req_if.sink           req_ch,
   output ezr_pkg::cls_type  cls_data,
   output logic              cls_valid,
   input  logic              cls_ready
);
   import ezr_pkg::*;

   logic    valid_ff;
   cls_type data_ff;
   cls_type data_in;
   logic    advance;

   function automatic angle_type classify(input logic signed [IN_W-1:0] raw);
      logic [RED_W-1:0]        u;
      logic signed [Z_W-1:0]   d;
      angle_type               res;
      u = RED_W'(raw) + OFS;
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (u >= (FULL << k)) u = u - (FULL << k);
      end
      d = signed'(Z_W'(u)) <<< (32 - ANGLE_FRAC_BITS);
      if (d > HALF) d = d - HALF - HALF;
      res.flip = 1'b0;
      if (d > QUART) begin
         d = HALF - d;
         res.flip = 1'b1;
      end else if (d < -QUART) begin
         d = -HALF - d;
         res.flip = 1'b1;
      end
      res.z = d;
      return res;
   endfunction

   assign advance      = !valid_ff || cls_ready;
   assign req_ch.ready = advance;

   always_comb begin
      data_in.a = classify(req_ch.first_z_angle);
      data_in.b = classify(req_ch.x_angle);
      data_in.c = classify(req_ch.second_z_angle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_ch.valid) begin
         data_ff <= data_in;
      end
   end

   assign cls_data  = data_ff;
   assign cls_valid = valid_ff;
endmodule

// File: hw/rtl/ezr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_queue: two-entry queue
// Decouples the intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module ezr_queue (
   input  logic              clock,
   input  logic              reset,
   input  ezr_pkg::cls_type  push_data,
   input  logic              push_valid,
   output logic              push_ready,
   output ezr_pkg::cls_type  pop_data,
   output logic              pop_valid,
   input  logic              pop_ready
);
   import ezr_pkg::*;

   cls_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: hw/rtl/ezr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_cordic: pipelined rotation-mode CORDIC
// One micro-rotation per stage, then rounding of sine and cosine to Q.30.
// ----------------------------------------------------------------------------
module ezr_cordic #(
   parameter int STEPS = ezr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  ezr_pkg::angle_type                ang,
   output logic                              out_valid,
   output logic signed [ezr_pkg::TRIG_W-1:0] sin_q30,
   output logic signed [ezr_pkg::TRIG_W-1:0] cos_q30
);
   import ezr_pkg::*;

   logic signed [XY_W-1:0] x_ff [STEPS];
   logic signed [XY_W-1:0] y_ff [STEPS];
   logic signed [Z_W-1:0]  z_ff [STEPS];
   logic                   flip_ff [STEPS];
   logic                   vld_ff [STEPS];

   logic                   out_vld_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [XY_W-1:0] x_rnd;
   logic signed [XY_W-1:0] y_rnd;
   logic signed [TRIG_W-1:0] cos_in;

   for (genvar gi = 0; gi < STEPS; gi++) begin : g_stage
      localparam logic signed [Z_W-1:0] STEP_ANG = Z_W'(atan_deg(gi));
      logic signed [XY_W-1:0] xi;
      logic signed [XY_W-1:0] yi;
      logic signed [Z_W-1:0]  zi;
      logic                   fi;
      logic                   vi;

      if (gi == 0) begin : g_first
         assign xi = GAIN;
         assign yi = '0;
         assign zi = ang.z;
         assign fi = ang.flip;
         assign vi = in_valid;
      end else begin : g_next
         assign xi = x_ff[gi-1];
         assign yi = y_ff[gi-1];
         assign zi = z_ff[gi-1];
         assign fi = flip_ff[gi-1];
         assign vi = vld_ff[gi-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[gi] <= 1'b0;
         end else if (en) begin
            vld_ff[gi] <= vi;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[gi] <= fi;
            if (zi >= 0) begin
               x_ff[gi] <= xi - (yi >>> gi);
               y_ff[gi] <= yi + (xi >>> gi);
               z_ff[gi] <= zi - STEP_ANG;
            end else begin
               x_ff[gi] <= xi + (yi >>> gi);
               y_ff[gi] <= yi - (xi >>> gi);
               z_ff[gi] <= zi + STEP_ANG;
            end
         end
      end
   end

   assign x_rnd  = (x_ff[STEPS-1] + XY_W'(512)) >>> 10;
   assign y_rnd  = (y_ff[STEPS-1] + XY_W'(512)) >>> 10;
   assign cos_in = flip_ff[STEPS-1] ? -x_rnd[TRIG_W-1:0] : x_rnd[TRIG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= y_rnd[TRIG_W-1:0];
         cos_ff <= cos_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign sin_q30   = sin_ff;
   assign cos_q30   = cos_ff;
endmodule

// File: hw/rtl/ezr_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_matrix: matrix composition pipeline
// Forms the nine products and sums of Z(a) X(b) Z(c) over four stages,
// the last of which is the output register.
// ----------------------------------------------------------------------------
module ezr_matrix (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [ezr_pkg::TRIG_W-1:0] sa,
   input  logic signed [ezr_pkg::TRIG_W-1:0] ca,
   input  logic signed [ezr_pkg::TRIG_W-1:0] sb,
   input  logic signed [ezr_pkg::TRIG_W-1:0] cb,
   input  logic signed [ezr_pkg::TRIG_W-1:0] sc,
   input  logic signed [ezr_pkg::TRIG_W-1:0] cc,
   output logic                              out_valid,
   output logic signed [ezr_pkg::OUT_W-1:0]  r00,
   output logic signed [ezr_pkg::OUT_W-1:0]  r01,
   output logic signed [ezr_pkg::OUT_W-1:0]  r02,
   output logic signed [ezr_pkg::OUT_W-1:0]  r10,
   output logic signed [ezr_pkg::OUT_W-1:0]  r11,
   output logic signed [ezr_pkg::OUT_W-1:0]  r12,
   output logic signed [ezr_pkg::OUT_W-1:0]  r20,
   output logic signed [ezr_pkg::OUT_W-1:0]  r21,
   output logic signed [ezr_pkg::OUT_W-1:0]  r22
);
   import ezr_pkg::*;

   localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(longint'(1) << 29);

   // Products that reach the final sums unchanged.
   typedef struct packed {
      logic signed [PROD_W-1:0] ca_cc;
      logic signed [PROD_W-1:0] ca_sc;
      logic signed [PROD_W-1:0] sa_sb;
      logic signed [PROD_W-1:0] sa_cc;
      logic signed [PROD_W-1:0] sa_sc;
      logic signed [PROD_W-1:0] ca_sb;
      logic signed [PROD_W-1:0] sb_sc;
      logic signed [PROD_W-1:0] sb_cc;
   } direct_type;

   logic [2:0]               vld_ff;
   logic                     out_vld_ff;

   direct_type               p1_ff;
   logic signed [PROD_W-1:0] sa_cb_ff;
   logic signed [PROD_W-1:0] ca_cb_ff;
   logic signed [TRIG_W-1:0] p1_cb_ff;
   logic signed [TRIG_W-1:0] p1_sc_ff;
   logic signed [TRIG_W-1:0] p1_cc_ff;

   direct_type               p2_ff;
   logic signed [TRIG_W-1:0] sacb_ff;
   logic signed [TRIG_W-1:0] cacb_ff;
   logic signed [TRIG_W-1:0] p2_cb_ff;
   logic signed [TRIG_W-1:0] p2_sc_ff;
   logic signed [TRIG_W-1:0] p2_cc_ff;
   logic signed [PROD_W-1:0] sacb_rnd;
   logic signed [PROD_W-1:0] cacb_rnd;

   direct_type               p3_ff;
   logic signed [PROD_W-1:0] sacb_sc_ff;
   logic signed [PROD_W-1:0] sacb_cc_ff;
   logic signed [PROD_W-1:0] cacb_sc_ff;
   logic signed [PROD_W-1:0] cacb_cc_ff;
   logic signed [TRIG_W-1:0] p3_cb_ff;

   logic signed [OUT_W-1:0]  r_ff [9];

   assign sacb_rnd = (sa_cb_ff + RND30) >>> 30;
   assign cacb_rnd = (ca_cb_ff + RND30) >>> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[1:0], in_valid};
         out_vld_ff <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: all first-level products.
         p1_ff.ca_cc <= PROD_W'(ca * cc);
         p1_ff.ca_sc <= PROD_W'(ca * sc);
         p1_ff.sa_sb <= PROD_W'(sa * sb);
         p1_ff.sa_cc <= PROD_W'(sa * cc);
         p1_ff.sa_sc <= PROD_W'(sa * sc);
         p1_ff.ca_sb <= PROD_W'(ca * sb);
         p1_ff.sb_sc <= PROD_W'(sb * sc);
         p1_ff.sb_cc <= PROD_W'(sb * cc);
         sa_cb_ff    <= PROD_W'(sa * cb);
         ca_cb_ff    <= PROD_W'(ca * cb);
         p1_cb_ff    <= cb;
         p1_sc_ff    <= sc;
         p1_cc_ff    <= cc;

         // Stage 2: bring the shared pair products back to Q.30.
         p2_ff    <= p1_ff;
         sacb_ff  <= sacb_rnd[TRIG_W-1:0];
         cacb_ff  <= cacb_rnd[TRIG_W-1:0];
         p2_cb_ff <= p1_cb_ff;
         p2_sc_ff <= p1_sc_ff;
         p2_cc_ff <= p1_cc_ff;

         // Stage 3: triple products.
         p3_ff      <= p2_ff;
         sacb_sc_ff <= PROD_W'(sacb_ff * p2_sc_ff);
         sacb_cc_ff <= PROD_W'(sacb_ff * p2_cc_ff);
         cacb_sc_ff <= PROD_W'(cacb_ff * p2_sc_ff);
         cacb_cc_ff <= PROD_W'(cacb_ff * p2_cc_ff);
         p3_cb_ff   <= p2_cb_ff;

         // Stage 4: sums, rounding and saturation into the output register.
         r_ff[0] <= emit(SUM_W'(p3_ff.ca_cc) - SUM_W'(sacb_sc_ff));
         r_ff[1] <= emit(SUM_W'(p3_ff.ca_sc) + SUM_W'(sacb_cc_ff));
         r_ff[2] <= emit(SUM_W'(p3_ff.sa_sb));
         r_ff[3] <= emit(-SUM_W'(p3_ff.sa_cc) - SUM_W'(cacb_sc_ff));
         r_ff[4] <= emit(-SUM_W'(p3_ff.sa_sc) + SUM_W'(cacb_cc_ff));
         r_ff[5] <= emit(SUM_W'(p3_ff.ca_sb));
         r_ff[6] <= emit(SUM_W'(p3_ff.sb_sc));
         r_ff[7] <= emit(-SUM_W'(p3_ff.sb_cc));
         r_ff[8] <= emit(SUM_W'(p3_cb_ff) <<< 30);
      end
   end

   assign out_valid = out_vld_ff;
   assign r00 = r_ff[0];
   assign r01 = r_ff[1];
   assign r02 = r_ff[2];
   assign r10 = r_ff[3];
   assign r11 = r_ff[4];
   assign r12 = r_ff[5];
   assign r20 = r_ff[6];
   assign r21 = r_ff[7];
   assign r22 = r_ff[8];
endmodule
